// ----- rtl/lav_pkg.sv -----
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

    localparam int FRAC_BITS   = 16;                 // fraction bits of every Q value
    localparam int WW          = 32;                 // word width of points and elements
    localparam int DW          = WW + 1;             // eye minus target, exact
    localparam int ZW          = FRAC_BITS + 2;      // unit vector component, signed
    localparam int YW          = FRAC_BITS + 3;      // z cross x component after rounding
    localparam int CW          = WW + ZW + 1;        // vector to normalise, signed
    localparam int MW          = CW;                 // its magnitude
    localparam int PW          = 2 * WW;             // product of two words
    localparam int AW          = 2 * WW + 1;         // accumulator
    localparam int NORM_HI     = 30;                 // normalised magnitude below 2^NORM_HI
    localparam int SQW         = 2 * NORM_HI + 2;    // sum of three squares
    localparam int ROOTW       = SQW / 2;            // its integer square root
    localparam int SRW         = ROOTW + 2;          // square root partial remainder
    localparam int SQRT_STEPS  = ROOTW;
    localparam int QW          = FRAC_BITS + 1;      // quotient magnitude
    localparam int NW          = NORM_HI + 1 + FRAC_BITS; // dividend
    localparam int RW          = ROOTW;              // divider remainder
    localparam int CNTW        = $clog2(SQRT_STEPS);

    localparam logic [AW-1:0] HALF   = AW'(1) << (FRAC_BITS - 1);
    localparam logic [QW-1:0] Q_MAX  = QW'(1) << FRAC_BITS;
    localparam logic [WW-1:0] ONE_W  = WW'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] SAT_HI = signed'((AW'(1) << (WW - 1)) - AW'(1));
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    typedef logic signed [WW-1:0] word_t;
    typedef logic signed [DW-1:0] dword_t;
    typedef logic signed [ZW-1:0] unit_t;
    typedef logic signed [YW-1:0] yunit_t;

    // one camera word as it travels through the queue
    typedef struct packed {
        word_t  [2:0] eye;
        word_t  [2:0] up;
        dword_t [2:0] d;
        logic         d_zero;
    } lav_item_t;

    // finished matrix, elem[row][column]
    typedef struct packed {
        logic               deg;
        word_t [3:0][3:0]   elem;
    } lav_mat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_SHIFT,
        S_MUL,
        S_ACC,
        S_STORE,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_DSTORE,
        S_HAND
    } lav_state_t;

    typedef enum logic [1:0] {
        T_SQ,
        T_CROSSC,
        T_CROSSY,
        T_DOT
    } lav_task_t;

    // round to FRAC_BITS, half away from zero
    function automatic logic signed [AW-1:0] round_frac(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        logic [AW-1:0] r;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        r = (m + HALF) >> FRAC_BITS;
        return v[AW-1] ? -signed'(r) : signed'(r);
    endfunction

    // negated, rounded, saturated to a word
    function automatic word_t sat_neg(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = -round_frac(v);
        if (r > SAT_HI)
            return word_t'(SAT_HI);
        else if (r < SAT_LO)
            return word_t'(SAT_LO);
        else
            return word_t'(r);
    endfunction

endpackage

// ----- rtl/lav_req_if.sv -----
// Camera word channel: eye, target and up vector.
`timescale 1ns / 1ps
interface lav_req_if import lav_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, output ready);
endinterface

// ----- rtl/lav_rsp_if.sv -----
// Matrix row channel: one group of four elements per word.
`timescale 1ns / 1ps
interface lav_rsp_if import lav_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] row_index;
    word_t      elem_a;
    word_t      elem_b;
    word_t      elem_c;
    word_t      elem_d;
    logic       last_row;
    logic       degenerate;

    modport source (output valid, row_index, elem_a, elem_b, elem_c, elem_d, last_row,
                    degenerate, input ready);
    modport sink   (input valid, row_index, elem_a, elem_b, elem_c, elem_d, last_row,
                    degenerate, output ready);
endinterface

// ----- rtl/lav_front.sv -----
// Front end: takes camera words, forms eye minus target and flags a zero view vector.
`timescale 1ns / 1ps
module lav_front import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lav_req_if.sink   req,
    output logic      push,
    output lav_item_t push_data,
    input  logic      push_ready
);

    logic      valid_reg;
    lav_item_t item_reg;
    lav_item_t item_next;

    assign req.ready = !valid_reg || push_ready;
    assign push      = valid_reg;
    assign push_data = item_reg;

    always_comb
    begin
        item_next.eye[0] = req.eye_x;
        item_next.eye[1] = req.eye_y;
        item_next.eye[2] = req.eye_z;
        item_next.up[0]  = req.up_x;
        item_next.up[1]  = req.up_y;
        item_next.up[2]  = req.up_z;
        item_next.d[0]   = DW'(req.eye_x) - DW'(req.target_x);
        item_next.d[1]   = DW'(req.eye_y) - DW'(req.target_y);
        item_next.d[2]   = DW'(req.eye_z) - DW'(req.target_z);
        item_next.d_zero = (req.eye_x == req.target_x) && (req.eye_y == req.target_y)
                           && (req.eye_z == req.target_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            item_reg <= item_next;
    end

endmodule

// ----- rtl/lav_fifo.sv -----
// Two-entry queue between the front end and the matrix engine.
`timescale 1ns / 1ps
module lav_fifo import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lav_item_t push_data,
    output logic      push_ready,
    input  logic      pop,
    output logic      pop_valid,
    output lav_item_t pop_data
);

    lav_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

// ----- rtl/lav_back.sv -----
// Matrix engine: normalise, cross and dot products over one shared multiplier.
`timescale 1ns / 1ps
module lav_back import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  lav_item_t item,
    output logic      pop,
    output logic      mat_valid,
    output lav_mat_t  mat,
    input  logic      mat_ready
);

    lav_state_t state_reg, state_next;
    lav_task_t  task_reg, task_next;
    logic       phase_reg, phase_next;      // 0: building z, 1: building x
    logic       deg_reg, deg_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] term_reg, term_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    word_t   eye_reg [3], eye_next [3];
    word_t   up_reg  [3], up_next  [3];
    logic signed [CW-1:0] vec_reg [3], vec_next [3];
    logic [MW-1:0] mag_reg [3], mag_next [3];
    logic [2:0] sgn_reg, sgn_next;
    unit_t   z_reg [3], z_next [3];
    unit_t   x_reg [3], x_next [3];
    yunit_t  y_reg [3], y_next [3];
    word_t   dot_reg [3], dot_next [3];

    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [SQW-1:0]   sq_reg, sq_next;
    logic [ROOTW-1:0] root_reg, root_next;
    logic [SRW-1:0]   srem_reg, srem_next;
    logic [RW-1:0]    drem_reg, drem_next;
    logic [QW-1:0]    nlo_reg, nlo_next;
    logic [QW-1:0]    q_reg, q_next;

    logic [MW-1:0] mx;
    logic          mx_zero, mx_big, mx_small;
    logic          norm_done;
    logic [1:0]    term_last;
    word_t         opa, opb;
    logic [SRW+1:0] srem_t, strial;
    logic          sge;
    logic [RW:0]   dt;
    logic          dge;
    logic [NW-1:0] dividend;
    unit_t         qval;

    // largest magnitude decides the common shift
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
            mx = mag_reg[1];
        if (mag_reg[2] > mx)
            mx = mag_reg[2];
    end

    assign mx_zero   = (mx == '0);
    assign mx_big    = |mx[MW-1:NORM_HI];
    assign mx_small  = ~|mx[MW-1:NORM_HI-1];
    assign term_last = (task_reg == T_SQ || task_reg == T_DOT) ? 2'd2 : 2'd1;
    assign norm_done = (state_reg == S_IDLE && item_valid && item.d_zero)
                    || (state_reg == S_SHIFT && mx_zero)
                    || (state_reg == S_DSTORE && comp_reg == 2'd2);

    // multiplier operands
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (task_reg)
            T_SQ:
            begin
                opa = word_t'(mag_reg[term_reg][NORM_HI-1:0]);
                opb = opa;
            end
            T_CROSSC:
            begin
                opa = (term_reg == 2'd0) ? up_reg[1] : up_reg[2];
                opb = (term_reg == 2'd0) ? WW'(z_reg[2]) : WW'(z_reg[1]);
            end
            T_CROSSY:
            begin
                opa = (term_reg == 2'd0) ? WW'(z_reg[1]) : WW'(z_reg[2]);
                opb = (term_reg == 2'd0) ? WW'(x_reg[2]) : WW'(x_reg[1]);
            end
            T_DOT:
            begin
                opb = eye_reg[term_reg];
                case (comp_reg)
                    2'd0:    opa = WW'(x_reg[term_reg]);
                    2'd1:    opa = WW'(y_reg[term_reg]);
                    default: opa = WW'(z_reg[term_reg]);
                endcase
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // square root and divider steps
    assign srem_t   = {srem_reg, sq_reg[SQW-1 -: 2]};
    assign strial   = (SRW+2)'({root_reg, 2'b01});
    assign sge      = (srem_t >= strial);
    assign dividend = (NW'(mag_reg[comp_reg][NORM_HI-1:0]) << FRAC_BITS)
                      + NW'(root_reg >> 1);
    assign dt       = {drem_reg, nlo_reg[QW-1]};
    assign dge      = (dt >= (RW+1)'(root_reg));
    assign qval     = sgn_reg[comp_reg] ? -signed'(ZW'(q_reg)) : signed'(ZW'(q_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (item_valid)
                    state_next = item.d_zero ? S_MUL : S_MAG;
            S_MAG:
                state_next = S_SHIFT;
            S_SHIFT:
                if (mx_zero || (!mx_big && !mx_small))
                    state_next = S_MUL;
            S_MUL:
                state_next = S_ACC;
            S_ACC:
                state_next = (term_reg == term_last) ? S_STORE : S_MUL;
            S_STORE:
                case (task_reg)
                    T_SQ:     state_next = S_SQRT;
                    T_CROSSC: state_next = (comp_reg == 2'd2) ? S_MAG : S_MUL;
                    T_DOT:    state_next = (comp_reg == 2'd2) ? S_HAND : S_MUL;
                    default:  state_next = S_MUL;
                endcase
            S_SQRT:
                if (cnt_reg == CNTW'(SQRT_STEPS - 1))
                    state_next = S_DINIT;
            S_DINIT:
                state_next = S_DIV;
            S_DIV:
                if (cnt_reg == CNTW'(QW - 1))
                    state_next = S_DSTORE;
            S_DSTORE:
                state_next = (comp_reg == 2'd2) ? S_MUL : S_DINIT;
            S_HAND:
                if (mat_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop       = (state_reg == S_IDLE) && item_valid;
        mat_valid = (state_reg == S_HAND);
        mat.deg   = deg_reg;
        for (int r = 0; r < 3; r++)
        begin
            mat.elem[r][0] = deg_reg ? '0 : WW'(x_reg[r]);
            mat.elem[r][1] = deg_reg ? '0 : WW'(y_reg[r]);
            mat.elem[r][2] = deg_reg ? '0 : WW'(z_reg[r]);
            mat.elem[r][3] = '0;
        end
        for (int c = 0; c < 3; c++)
            mat.elem[3][c] = deg_reg ? '0 : dot_reg[c];
        mat.elem[3][3] = deg_reg ? '0 : word_t'(ONE_W);
    end

    // datapath
    always_comb
    begin
        task_next  = task_reg;
        phase_next = phase_reg;
        deg_next   = deg_reg;
        comp_next  = comp_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        eye_next   = eye_reg;
        up_next    = up_reg;
        vec_next   = vec_reg;
        mag_next   = mag_reg;
        sgn_next   = sgn_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dot_next   = dot_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        drem_next  = drem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;

        case (state_reg)
            S_IDLE:
                if (item_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_next[i] = signed'(item.eye[i]);
                        up_next[i]  = signed'(item.up[i]);
                        vec_next[i] = CW'(signed'(item.d[i]));
                    end
                    phase_next = 1'b0;
                    deg_next   = item.d_zero;
                    if (item.d_zero)
                        for (int i = 0; i < 3; i++)
                            z_next[i] = '0;
                end
            S_MAG:
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i] = vec_reg[i][CW-1] ? MW'(-vec_reg[i]) : MW'(vec_reg[i]);
                    sgn_next[i] = vec_reg[i][CW-1];
                end
            S_SHIFT:
                if (mx_zero)
                begin
                    deg_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (phase_reg)
                            x_next[i] = '0;
                        else
                            z_next[i] = '0;
                    end
                end
                else if (mx_big)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if (mx_small)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    task_next = T_SQ;
                    term_next = 2'd0;
                    acc_next  = '0;
                end
            S_MUL:
                prod_next = opa * opb;
            S_ACC:
            begin
                if ((task_reg == T_CROSSC || task_reg == T_CROSSY) && term_reg == 2'd1)
                    acc_next = acc_reg - AW'(prod_reg);
                else
                    acc_next = acc_reg + AW'(prod_reg);
                if (term_reg != term_last)
                    term_next = term_reg + 2'd1;
            end
            S_STORE:
            begin
                term_next = 2'd0;
                acc_next  = '0;
                comp_next = (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                case (task_reg)
                    T_SQ:
                    begin
                        sq_next   = SQW'(acc_reg);
                        root_next = '0;
                        srem_next = '0;
                        cnt_next  = '0;
                        comp_next = comp_reg;
                    end
                    T_CROSSC:
                    begin
                        vec_next[0] = vec_reg[1];
                        vec_next[1] = vec_reg[2];
                        vec_next[2] = CW'(acc_reg);
                        up_next[0]  = up_reg[1];
                        up_next[1]  = up_reg[2];
                        up_next[2]  = up_reg[0];
                        z_next[0]   = z_reg[1];
                        z_next[1]   = z_reg[2];
                        z_next[2]   = z_reg[0];
                        if (comp_reg == 2'd2)
                            phase_next = 1'b1;
                    end
                    T_CROSSY:
                    begin
                        y_next[0] = y_reg[1];
                        y_next[1] = y_reg[2];
                        y_next[2] = YW'(round_frac(acc_reg));
                        z_next[0] = z_reg[1];
                        z_next[1] = z_reg[2];
                        z_next[2] = z_reg[0];
                        x_next[0] = x_reg[1];
                        x_next[1] = x_reg[2];
                        x_next[2] = x_reg[0];
                        if (comp_reg == 2'd2)
                            task_next = T_DOT;
                    end
                    default:
                    begin
                        dot_next[0] = dot_reg[1];
                        dot_next[1] = dot_reg[2];
                        dot_next[2] = sat_neg(acc_reg);
                    end
                endcase
            end
            S_SQRT:
            begin
                srem_next = SRW'(sge ? srem_t - strial : srem_t);
                root_next = {root_reg[ROOTW-2:0], sge};
                sq_next   = sq_reg << 2;
                cnt_next  = cnt_reg + CNTW'(1);
                comp_next = 2'd0;
            end
            S_DINIT:
            begin
                drem_next = RW'(dividend[NW-1:QW]);
                nlo_next  = dividend[QW-1:0];
                q_next    = '0;
                cnt_next  = '0;
            end
            S_DIV:
            begin
                drem_next = RW'(dge ? dt - (RW+1)'(root_reg) : dt);
                nlo_next  = nlo_reg << 1;
                q_next    = {q_reg[QW-2:0], dge};
                cnt_next  = cnt_reg + CNTW'(1);
            end
            S_DSTORE:
            begin
                if (phase_reg)
                begin
                    x_next[0] = x_reg[1];
                    x_next[1] = x_reg[2];
                    x_next[2] = qval;
                end
                else
                begin
                    z_next[0] = z_reg[1];
                    z_next[1] = z_reg[2];
                    z_next[2] = qval;
                end
                comp_next = comp_reg + 2'd1;
            end
            default:
            begin
            end
        endcase

        // a finished unit vector leads into the next cross product
        if (norm_done)
        begin
            task_next = phase_next ? T_CROSSY : T_CROSSC;
            comp_next = 2'd0;
            term_next = 2'd0;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            task_reg  <= T_SQ;
            phase_reg <= 1'b0;
            deg_reg   <= 1'b0;
            comp_reg  <= 2'd0;
            term_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            task_reg  <= task_next;
            phase_reg <= phase_next;
            deg_reg   <= deg_next;
            comp_reg  <= comp_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eye_reg  <= eye_next;
        up_reg   <= up_next;
        vec_reg  <= vec_next;
        mag_reg  <= mag_next;
        sgn_reg  <= sgn_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        dot_reg  <= dot_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        drem_reg <= drem_next;
        nlo_reg  <= nlo_next;
        q_reg    <= q_next;
    end

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (root_reg != '0))
        else $error("divide by zero length");

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTORE) |-> (q_reg <= Q_MAX))
        else $error("unit component above one");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ACC) |-> (term_reg <= term_last))
        else $error("product term out of range");

endmodule

// ----- rtl/lav_emit.sv -----
// Row emitter: holds one finished matrix and sends it as four row words.
`timescale 1ns / 1ps
module lav_emit import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mat_valid,
    input  lav_mat_t  mat,
    output logic      mat_ready,
    lav_rsp_if.source rsp
);

    lav_mat_t   bank_reg;
    logic       busy_reg;
    logic [1:0] row_reg;
    logic       load;
    logic       take;

    assign take      = rsp.valid && rsp.ready;
    assign mat_ready = !busy_reg || (take && row_reg == 2'd3);
    assign load      = mat_valid && mat_ready;

    assign rsp.valid      = busy_reg;
    assign rsp.row_index  = row_reg;
    assign rsp.elem_a     = bank_reg.elem[row_reg][0];
    assign rsp.elem_b     = bank_reg.elem[row_reg][1];
    assign rsp.elem_c     = bank_reg.elem[row_reg][2];
    assign rsp.elem_d     = bank_reg.elem[row_reg][3];
    assign rsp.last_row   = (row_reg == 2'd3);
    assign rsp.degenerate = bank_reg.deg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            row_reg  <= 2'd0;
        end
        else if (take)
        begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == 2'd3)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bank_reg <= mat;
    end

    a_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (row_reg == 2'd0))
        else $error("row count not reset while idle");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && row_reg == 2'd3 && !load) |=> !busy_reg)
        else $error("emitter still busy after last row");

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// Top level of the look-at view matrix block.
// Takes one camera word (eye, target, up; signed Q16.16) on req and returns four row
// words on rsp, rows 0 to 2 holding x, y, z components and 0, row 3 the negated,
// rounded and saturated dot products of x, y, z with the eye and then 1.0; last_row
// marks row 3 and degenerate marks a zero-length view or side vector, in which case
// every element is zero. A word holds the engine for one pass, plus any wait for
// the emitter to take the finished matrix. Two normalisations dominate. Each starts
// with a shift search that moves one bit a cycle. The rest of a normalisation is a
// 31-step bit-serial square root and three 17-step restoring divisions, each with
// a set-up state and a store state. Cross and dot products pass each term through
// a multiply state and an accumulate state on the single 32x32 multiplier. A
// degenerate word is shorter when the eye sits on the target or when up is parallel
// to the view vector. The engine works on one word at a time, so the sustained rate
// is one camera word per engine pass. The front end and a two-word queue keep
// taking camera words while the engine works. The row emitter holds a finished
// matrix, so the engine starts the next word while rows drain.
`timescale 1ns / 1ps
module look_at_view_matrix import lav_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lav_req_if.sink   req,
    lav_rsp_if.source rsp
);

    logic      push;
    lav_item_t push_data;
    logic      push_ready;
    logic      pop;
    logic      pop_valid;
    lav_item_t pop_data;
    logic      mat_valid;
    lav_mat_t  mat;
    logic      mat_ready;

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    lav_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    lav_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_data),
        .pop        (pop),
        .mat_valid  (mat_valid),
        .mat        (mat),
        .mat_ready  (mat_ready)
    );

    lav_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat        (mat),
        .mat_ready  (mat_ready),
        .rsp        (rsp)
    );

endmodule

// ----- verif/tb_look_at_view_matrix.sv -----
// Self-checking testbench of the look-at view matrix block.
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
    import lav_pkg::*;

    localparam int N_RANDOM   = 416;
    localparam int CYCLE_MAX  = 2000000;
    localparam int DRAIN_WAIT = 500;     // one engine pass plus margin

    typedef struct {
        word_t eye_x, eye_y, eye_z;
        word_t tgt_x, tgt_y, tgt_z;
        word_t up_x, up_y, up_z;
    } camera_t;

    typedef struct {
        logic [1:0] row;
        word_t      a, b, c, d;
        logic       last;
        logic       deg;
    } row_word_t;

    logic clk;
    logic rst_n;

    lav_req_if req ();
    lav_rsp_if rsp ();

    look_at_view_matrix dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    camera_t   camera_q[$];
    row_word_t rows_due_q[$];
    int        errors;
    int        cycles;
    int        req_gap;
    int        rsp_gap;
    bit        quiet_spell;     // stretch with no idling on either side
    bit        req_took;        // req word accepted at the last rising edge

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: fixed point look-at matrix, FRAC_BITS fraction bits
    // ---------------------------------------------------------------------
    function automatic longint unsigned mag64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // round to FRAC_BITS, half away from zero
    function automatic longint round_q(input longint v);
        longint unsigned m;
        longint unsigned r;
        m = mag64(v);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale largest magnitude into [2^29, 2^30), then divide by the length
    function automatic bit unit_vec(input longint v [3], output longint u [3]);
        longint unsigned m [3];
        longint unsigned mx, sum, len, q;
        int dn, upw;
        mx  = 0;
        sum = 0;
        dn  = 0;
        upw = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag64(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        while ((mx >> dn) >= (64'd1 << 30))
            dn++;
        while ((mx << upw) < (64'd1 << 29))
            upw++;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (m[i] >> dn) << upw;
            sum  = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q    = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic word_t neg_dot_clip(input longint a [3], input longint e [3]);
        longint r;
        r = -round_q(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return word_t'(r);
    endfunction

    // push the four row words that one camera word must produce
    function automatic void predict_view_rows(input camera_t cam);
        longint    eye [3], up [3], dv [3], cr [3], zc [3], xc [3], yc [3];
        word_t     mat [16];
        bit        ok;
        row_word_t rw;
        eye = '{cam.eye_x, cam.eye_y, cam.eye_z};
        up  = '{cam.up_x, cam.up_y, cam.up_z};
        dv  = '{eye[0] - longint'(cam.tgt_x), eye[1] - longint'(cam.tgt_y),
                eye[2] - longint'(cam.tgt_z)};
        ok = unit_vec(dv, zc);
        cr[0] = up[1] * zc[2] - up[2] * zc[1];
        cr[1] = up[2] * zc[0] - up[0] * zc[2];
        cr[2] = up[0] * zc[1] - up[1] * zc[0];
        ok = unit_vec(cr, xc) && ok;
        yc[0] = round_q(zc[1] * xc[2] - zc[2] * xc[1]);
        yc[1] = round_q(zc[2] * xc[0] - zc[0] * xc[2]);
        yc[2] = round_q(zc[0] * xc[1] - zc[1] * xc[0]);
        foreach (mat[i])
            mat[i] = '0;
        if (ok)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mat[4*i]   = word_t'(xc[i]);
                mat[4*i+1] = word_t'(yc[i]);
                mat[4*i+2] = word_t'(zc[i]);
            end
            mat[12] = neg_dot_clip(xc, eye);
            mat[13] = neg_dot_clip(yc, eye);
            mat[14] = neg_dot_clip(zc, eye);
            mat[15] = ONE_W;
        end
        for (int k = 0; k < 4; k++)
        begin
            rw.row  = 2'(k);
            rw.a    = mat[4*k];
            rw.b    = mat[4*k+1];
            rw.c    = mat[4*k+2];
            rw.d    = mat[4*k+3];
            rw.last = (k == 3);
            rw.deg  = !ok;
            rows_due_q.push_back(rw);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if (quiet_spell)
            return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5, 6:    return $urandom_range(1, 3);
            7, 8:       return $urandom_range(4, 12);
            default:    return $urandom_range(20, 120);
        endcase
    endfunction

    // coordinate: full range, scene sized, tiny, or an extreme
    function automatic word_t pick_coord();
        case ($urandom_range(0, 9))
            0, 1:    return word_t'($urandom);
            2:       return word_t'($urandom_range(0, 8)) - 4;
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return word_t'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
        endcase
    endfunction

    function automatic camera_t make_cam(input word_t ex, ey, ez, tx, ty, tz,
                                         ux, uy, uz);
        camera_t c;
        c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
        c.tgt_x = tx; c.tgt_y = ty; c.tgt_z = tz;
        c.up_x  = ux; c.up_y  = uy; c.up_z  = uz;
        return c;
    endfunction

    function automatic camera_t random_cam();
        camera_t c;
        word_t   s;
        c = make_cam(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord());
        case ($urandom_range(0, 19))
            // eye on the target
            0:
            begin
                c.tgt_x = c.eye_x; c.tgt_y = c.eye_y; c.tgt_z = c.eye_z;
            end
            // up along an axis-aligned view direction
            1:
            begin
                s = word_t'($urandom_range(1, 32'h0010_0000));
                c.tgt_x = c.eye_x; c.tgt_y = c.eye_y;
                c.tgt_z = c.eye_z - s;
                c.up_x = 0; c.up_y = 0;
                c.up_z = ($urandom_range(0, 1)) ? s : -s;
            end
            2:
            begin
                c.up_x = 0; c.up_y = 0; c.up_z = 0;
            end
            // the usual camera: y up
            3, 4, 5:
            begin
                c.up_x = 0; c.up_y = ONE_W; c.up_z = 0;
            end
            default: ;
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: req side, changes at the falling edge
    // ---------------------------------------------------------------------
    always @(posedge clk)
        req_took <= req.valid && req.ready;

    always @(negedge clk)
    begin
        logic    nxt_valid;
        camera_t c;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            nxt_valid = req.valid && !req_took;
            if (!nxt_valid)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (camera_q.size() > 0)
                begin
                    c = camera_q.pop_front();
                    req.eye_x    <= c.eye_x;
                    req.eye_y    <= c.eye_y;
                    req.eye_z    <= c.eye_z;
                    req.target_x <= c.tgt_x;
                    req.target_y <= c.tgt_y;
                    req.target_z <= c.tgt_z;
                    req.up_x     <= c.up_x;
                    req.up_y     <= c.up_y;
                    req.up_z     <= c.up_z;
                    nxt_valid = 1'b1;
                    req_gap   = pick_gap();
                end
            end
            req.valid <= nxt_valid;
        end
    end

    // rsp back-pressure, same edge
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rsp_gap = pick_gap();
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predict on req acceptance, check on rsp acceptance
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        row_word_t want;
        camera_t   c;
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                c = make_cam(req.eye_x, req.eye_y, req.eye_z, req.target_x,
                             req.target_y, req.target_z, req.up_x, req.up_y, req.up_z);
                predict_view_rows(c);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (rows_due_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected row word, row %0d", $time, rsp.row_index);
                end
                else
                begin
                    want = rows_due_q.pop_front();
                    if (rsp.row_index !== want.row || rsp.last_row !== want.last ||
                        rsp.degenerate !== want.deg)
                    begin
                        errors++;
                        $display("%0t: row/last/deg expected %0d/%0b/%0b actual %0d/%0b/%0b",
                                 $time, want.row, want.last, want.deg,
                                 rsp.row_index, rsp.last_row, rsp.degenerate);
                    end
                    if (rsp.elem_a !== want.a || rsp.elem_b !== want.b ||
                        rsp.elem_c !== want.c || rsp.elem_d !== want.d)
                    begin
                        errors++;
                        $display("%0t: row %0d expected %h %h %h %h actual %h %h %h %h",
                                 $time, want.row, want.a, want.b, want.c, want.d,
                                 rsp.elem_a, rsp.elem_b, rsp.elem_c, rsp.elem_d);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        word_t one, mx, mn;
        one = ONE_W;
        mx  = 32'h7FFF_FFFF;
        mn  = 32'h8000_0000;
        errors      = 0;
        cycles      = 0;
        req_gap     = 0;
        rsp_gap     = 0;
        quiet_spell = 1'b0;
        req_took    = 1'b0;
        rst_n       = 1'b0;
        req.valid = 1'b0;
        req.eye_x = '0; req.eye_y = '0; req.eye_z = '0;
        req.target_x = '0; req.target_y = '0; req.target_z = '0;
        req.up_x = '0; req.up_y = '0; req.up_z = '0;
        rsp.ready = 1'b0;

        // directed words
        camera_q.push_back(make_cam(0, 0, 5*one, 0, 0, 0, 0, one, 0));
        camera_q.push_back(make_cam(3*one, 2*one, one, 0, 0, 0, 0, one, 0));
        camera_q.push_back(make_cam(one, one, one, one, one, one, 0, one, 0));  // eye on target
        camera_q.push_back(make_cam(0, 0, 0, 0, 0, 0, 0, 0, 0));
        camera_q.push_back(make_cam(0, 0, one, 0, 0, 0, 0, 0, 0));              // zero up
        camera_q.push_back(make_cam(0, 0, one, 0, 0, 0, 0, 0, 7*one));          // up along view
        camera_q.push_back(make_cam(0, 0, one, 0, 0, 0, 0, 0, -one));
        camera_q.push_back(make_cam(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        camera_q.push_back(make_cam(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        camera_q.push_back(make_cam(mx, mn, mx, 0, 0, 0, 0, one, 0));           // dot saturates
        camera_q.push_back(make_cam(mn, mx, mn, 0, 0, 0, 0, one, 0));
        camera_q.push_back(make_cam(1, 0, 0, 0, 0, 0, 0, 1, 0));                // one lsb apart
        camera_q.push_back(make_cam(0, 0, 0, 0, 1, 0, 0, 0, 1));
        camera_q.push_back(make_cam(-32'sd1, -32'sd1, -32'sd1, 0, 0, 0, 1, 0, 0));
        camera_q.push_back(make_cam(10*one, -4*one, 7*one, -one, 2*one, -3*one,
                                    one/2, one, -one/4));
        camera_q.push_back(make_cam(mx, 0, 0, mn, 0, 0, 0, mx, 0));             // 33-bit diff
        for (int i = 0; i < N_RANDOM; i++)
            camera_q.push_back(random_cam());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // toggle no-idle stretches while the stimulus drains
        while (camera_q.size() > 0 || req.valid)
        begin
            @(posedge clk);
            if ($urandom_range(0, 999) == 0)
                quiet_spell = !quiet_spell;
        end
        while (rows_due_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && rows_due_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lav_pkg.sv
rtl/lav_req_if.sv
rtl/lav_rsp_if.sv
rtl/lav_front.sv
rtl/lav_fifo.sv
rtl/lav_back.sv
rtl/lav_emit.sv
rtl/look_at_view_matrix.sv
verif/tb_look_at_view_matrix.sv
